### rtl/bpc_pkg.sv
package bpc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_OVERSAMPLING   = 3'd0,
		REG_CAL_SIGNED_A   = 3'd1,
		REG_CAL_UNSIGNED_A = 3'd2,
		REG_CAL_B_PAIR     = 3'd3,
		REG_CAL_M_TRIPLE   = 3'd4
	} reg_idx_t;

	// Calibration set, unpacked from the configuration words
	typedef struct packed {
		logic [1:0]  oss;
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
	} cal_t;

	localparam int unsigned CFG_DATA_W = 48;

	localparam logic signed [29:0] B6_OFFSET  = 30'sd4000;
	localparam logic [15:0]        B7_SCALE   = 16'd50000;
	localparam logic [31:0]        X3_BIAS    = 32'd32768;
	localparam logic [11:0]        P_SQ_COEF  = 12'd3038;
	localparam logic signed [13:0] P_LIN_COEF = -14'sd7357;
	localparam logic signed [49:0] P_OFFSET   = 50'sd3791;
	localparam logic signed [25:0] T_MAX      = 26'sd32767;
	localparam logic signed [25:0] T_MIN      = -26'sd32768;
	localparam logic signed [50:0] P_MAX      = 51'sd262143;

endpackage

### rtl/baro_pressure_temp_compensation.sv
// Channel   Ports                                         Handshake
// --------  --------------------------------------------  -----------------------------
// request   start, raw_temperature, raw_pressure_reg      taken when start && !busy
// result    done, temperature_tenths, pressure_pa,        valid for the single cycle
//           divide_fault                                  that done is high
// config    cfg_wen, cfg_index, cfg_wdata                 written when cfg_wen is high
//
// One request may enter every cycle; busy stays low.
// Between start and done lie the two one-bit-per-stage dividers
// (27 stages for X2, 33 for pressure) plus the multiply stages.
// arst_n clears the valid pipeline and the configuration registers.
// The receiver cannot stall, so the pipeline advances every cycle.
module baro_pressure_temp_compensation import bpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [15:0]           raw_temperature,
	input  logic [23:0]           raw_pressure_reg,
	output logic                  done,
	output logic signed [15:0]    temperature_tenths,
	output logic [17:0]           pressure_pa,
	output logic                  divide_fault,
	input  logic                  cfg_wen,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [1:0]         oversampling_q;
	logic [47:0]        cal_signed_a_q;
	logic [47:0]        cal_unsigned_a_q;
	logic [31:0]        cal_b_pair_q;
	logic [47:0]        cal_m_triple_q;
	cal_t               cal;
	logic               tv;
	logic signed [28:0] tb5;
	logic               tfault;
	logic [23:0]        traw;

	// Hold configuration; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oversampling_q   <= '0;
			cal_signed_a_q   <= '0;
			cal_unsigned_a_q <= '0;
			cal_b_pair_q     <= '0;
			cal_m_triple_q   <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_OVERSAMPLING:   oversampling_q   <= cfg_wdata[1:0];
				REG_CAL_SIGNED_A:   cal_signed_a_q   <= cfg_wdata[47:0];
				REG_CAL_UNSIGNED_A: cal_unsigned_a_q <= cfg_wdata[47:0];
				REG_CAL_B_PAIR:     cal_b_pair_q     <= cfg_wdata[31:0];
				REG_CAL_M_TRIPLE:   cal_m_triple_q   <= cfg_wdata[47:0];
				default: ;
			endcase
		end
	end

	// Unpack calibration words
	assign cal.oss = oversampling_q;
	assign cal.ac1 = cal_signed_a_q[15:0];
	assign cal.ac2 = cal_signed_a_q[31:16];
	assign cal.ac3 = cal_signed_a_q[47:32];
	assign cal.ac4 = cal_unsigned_a_q[15:0];
	assign cal.ac5 = cal_unsigned_a_q[31:16];
	assign cal.ac6 = cal_unsigned_a_q[47:32];
	assign cal.b1  = cal_b_pair_q[15:0];
	assign cal.b2  = cal_b_pair_q[31:16];
	assign cal.mc  = cal_m_triple_q[31:16];
	assign cal.md  = cal_m_triple_q[47:32];

	assign busy = 1'b0;

	bpc_temp u_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal),
		.in_valid (start),
		.ut       (raw_temperature),
		.raw_p    (raw_pressure_reg),
		.out_valid(tv),
		.b5       (tb5),
		.fault    (tfault),
		.raw_p_out(traw)
	);

	bpc_press u_press (
		.clk               (clk),
		.arst_n            (arst_n),
		.cal               (cal),
		.in_valid          (tv),
		.b5                (tb5),
		.fault_in          (tfault),
		.raw_p             (traw),
		.done              (done),
		.temperature_tenths(temperature_tenths),
		.pressure_pa       (pressure_pa),
		.divide_fault      (divide_fault)
	);

endmodule

### rtl/bpc_udiv.sv
module bpc_udiv #(
	parameter int unsigned DIVIDEND_W = 27,
	parameter int unsigned DIVISOR_W  = 19,
	parameter int unsigned SIDE_W     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	input  logic [SIDE_W-1:0]     side_in,
	output logic                  out_valid,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [SIDE_W-1:0]     side_out
);

	logic                  vld_s  [0:DIVIDEND_W];
	logic [DIVISOR_W-1:0]  rem_s  [0:DIVIDEND_W];
	logic [DIVIDEND_W-1:0] dq_s   [0:DIVIDEND_W];
	logic [DIVISOR_W-1:0]  dvs_s  [0:DIVIDEND_W];
	logic [SIDE_W-1:0]     side_s [0:DIVIDEND_W];

	// Entry: empty remainder, dividend bits waiting to shift in
	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign dq_s[0]   = dividend;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;

	// One restoring step per stage, quotient bits shift in from the right
	for (genvar k = 0; k < DIVIDEND_W; k++) begin : g_stage
		logic [DIVISOR_W:0] trial;
		logic [DIVISOR_W:0] diff;
		logic               take;

		assign trial = {rem_s[k], dq_s[k][DIVIDEND_W-1]};
		assign diff  = trial - {1'b0, dvs_s[k]};
		assign take  = ~diff[DIVISOR_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			dq_s[k+1]   <= {dq_s[k][DIVIDEND_W-2:0], take};
			dvs_s[k+1]  <= dvs_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[DIVIDEND_W];
	assign quotient  = dq_s[DIVIDEND_W];
	assign side_out  = side_s[DIVIDEND_W];

endmodule

### rtl/bpc_temp.sv
module bpc_temp import bpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cal_t               cal,
	input  logic               in_valid,
	input  logic [15:0]        ut,
	input  logic [23:0]        raw_p,
	output logic               out_valid,
	output logic signed [28:0] b5,
	output logic               fault,
	output logic [23:0]        raw_p_out
);

	localparam int unsigned SIDE_W = 19 + 1 + 1 + 24;

	logic               vld_s1;
	logic signed [33:0] prod_s1;
	logic [23:0]        rawp_s1;

	logic               vld_s2;
	logic signed [18:0] x1_s2;
	logic signed [19:0] div_s2;
	logic [23:0]        rawp_s2;

	logic signed [16:0] ut_d;
	logic signed [18:0] x1_c;
	logic signed [15:0] mc_v;
	logic signed [16:0] mc_ext;
	logic [15:0]        mc_mag;
	logic [19:0]        div_abs;
	logic [26:0]        num_mag;
	logic [18:0]        den_mag;
	logic               neg_q;
	logic               zero_d;
	logic [SIDE_W-1:0]  side_in;

	logic               dv_vld;
	logic [26:0]        dv_q;
	logic [SIDE_W-1:0]  dv_side;
	logic signed [18:0] x1_d;
	logic               neg_d;
	logic               zero_q;
	logic [23:0]        rawp_d;
	logic signed [27:0] x2_c;

	// Stage 1: (UT - AC6) * AC5
	assign ut_d = $signed({1'b0, ut}) - $signed({1'b0, cal.ac6});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ut_d * $signed({1'b0, cal.ac5});
		rawp_s1 <= raw_p;
	end

	// Stage 2: X1 and the divisor X1 + MD
	assign x1_c = $signed(prod_s1[33:15]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x1_s2   <= x1_c;
		div_s2  <= x1_c + $signed(cal.md);
		rawp_s2 <= rawp_s1;
	end

	// Fold signs into magnitudes for the unsigned divider
	assign mc_v    = $signed(cal.mc);
	assign mc_ext  = mc_v[15] ? -$signed({mc_v[15], mc_v}) : $signed({mc_v[15], mc_v});
	assign mc_mag  = mc_ext[15:0];
	assign num_mag = {mc_mag, 11'b0};
	assign div_abs = div_s2[19] ? 20'(-div_s2) : 20'(div_s2);
	assign den_mag = div_abs[18:0];
	assign neg_q   = mc_v[15] ^ div_s2[19];
	assign zero_d  = (div_s2 == 20'sd0);
	assign side_in = {x1_s2, neg_q, zero_d, rawp_s2};

	bpc_udiv #(
		.DIVIDEND_W(27),
		.DIVISOR_W (19),
		.SIDE_W    (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.dividend (num_mag),
		.divisor  (den_mag),
		.side_in  (side_in),
		.out_valid(dv_vld),
		.quotient (dv_q),
		.side_out (dv_side)
	);

	// Final stage: restore sign of X2 and form B5
	assign {x1_d, neg_d, zero_q, rawp_d} = dv_side;
	assign x2_c = neg_d ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		b5        <= x1_d + x2_c;
		fault     <= zero_q;
		raw_p_out <= rawp_d;
	end

endmodule

### rtl/bpc_press.sv
module bpc_press import bpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cal_t               cal,
	input  logic               in_valid,
	input  logic signed [28:0] b5,
	input  logic               fault_in,
	input  logic [23:0]        raw_p,
	output logic               done,
	output logic signed [15:0] temperature_tenths,
	output logic [17:0]        pressure_pa,
	output logic               divide_fault
);

	localparam int unsigned SIDE_W = 16 + 1 + 1;

	// Stage 1
	logic               vld_s1;
	logic signed [29:0] b6_s1;
	logic [15:0]        t_s1;
	logic [18:0]        up_s1;
	logic               flt_s1;
	// Stage 2
	logic               vld_s2;
	logic signed [59:0] sqf_s2;
	logic signed [45:0] ac2b6_s2;
	logic signed [45:0] ac3b6_s2;
	logic [15:0]        t_s2;
	logic [18:0]        up_s2;
	logic               flt_s2;
	// Stage 3
	logic               vld_s3;
	logic signed [64:0] b2sq_s3;
	logic signed [64:0] b1sq_s3;
	logic signed [45:0] ac2b6_s3;
	logic signed [45:0] ac3b6_s3;
	logic [15:0]        t_s3;
	logic [18:0]        up_s3;
	logic               flt_s3;
	// Stage 4
	logic               vld_s4;
	logic signed [55:0] suma_s4;
	logic signed [50:0] sumb_s4;
	logic [15:0]        t_s4;
	logic [18:0]        up_s4;
	logic               flt_s4;
	// Stage 5
	logic               vld_s5;
	logic [31:0]        b3_s5;
	logic [31:0]        op4_s5;
	logic [15:0]        t_s5;
	logic [18:0]        up_s5;
	logic               flt_s5;
	// Stage 6
	logic               vld_s6;
	logic [31:0]        b7_s6;
	logic [31:0]        b4p_s6;
	logic [15:0]        t_s6;
	logic               flt_s6;
	// Stage 8 onwards, after the divider
	logic               vld_s8;
	logic [33:0]        p0_s8;
	logic [15:0]        t_s8;
	logic               flt_s8;
	logic               vld_s9;
	logic [51:0]        sqp_s9;
	logic signed [48:0] m2_s9;
	logic [33:0]        p0_s9;
	logic [15:0]        t_s9;
	logic               flt_s9;
	logic               vld_s10;
	logic [47:0]        x1c_s10;
	logic signed [32:0] x2c_s10;
	logic [33:0]        p0_s10;
	logic [15:0]        t_s10;
	logic               flt_s10;

	logic signed [29:0] b5p8;
	logic signed [25:0] tt;
	logic [15:0]        t_c;
	logic [3:0]         up_sh;
	logic [23:0]        up_full;
	logic signed [48:0] sq_c;
	logic signed [53:0] x1a;
	logic signed [34:0] x2a;
	logic signed [32:0] x1b;
	logic signed [48:0] x2b;
	logic signed [59:0] w_c;
	logic [31:0]        b3_corr;
	logic [31:0]        x3_lo;
	logic [31:0]        diff_u;
	logic [15:0]        b7_k;
	logic [47:0]        b7_w;
	logic [47:0]        b4_w;
	logic [16:0]        b4;
	logic [32:0]        dvd;
	logic               big_b7;
	logic               flt_c;
	logic [SIDE_W-1:0]  side_in;
	logic               dv_vld;
	logic [32:0]        dv_q;
	logic [SIDE_W-1:0]  dv_side;
	logic [15:0]        t_d;
	logic               flt_d;
	logic               big_d;
	logic [63:0]        sqc_w;
	logic signed [49:0] corr_sum;
	logic signed [50:0] pf;
	logic [17:0]        p_sat;

	// Stage 1: B6, saturated temperature, UP
	assign b5p8    = b5 + 30'sd8;
	assign tt      = $signed(b5p8[29:4]);
	assign t_c     = (tt > T_MAX) ? 16'h7FFF : (tt < T_MIN) ? 16'h8000 : tt[15:0];
	assign up_sh   = 4'd8 - {2'b00, cal.oss};
	assign up_full = raw_p >> up_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		b6_s1  <= b5 - B6_OFFSET;
		t_s1   <= t_c;
		up_s1  <= up_full[18:0];
		flt_s1 <= fault_in;
	end

	// Stage 2: B6 squared and the linear B6 products
	always_ff @(posedge clk) begin
		sqf_s2   <= b6_s1 * b6_s1;
		ac2b6_s2 <= $signed(cal.ac2) * b6_s1;
		ac3b6_s2 <= $signed(cal.ac3) * b6_s1;
		t_s2     <= t_s1;
		up_s2    <= up_s1;
		flt_s2   <= flt_s1;
	end

	// Stage 3: B2 and B1 times the scaled square
	assign sq_c = $signed({1'b0, sqf_s2[59:12]});

	always_ff @(posedge clk) begin
		b2sq_s3  <= $signed(cal.b2) * sq_c;
		b1sq_s3  <= $signed(cal.b1) * sq_c;
		ac2b6_s3 <= ac2b6_s2;
		ac3b6_s3 <= ac3b6_s2;
		t_s3     <= t_s2;
		up_s3    <= up_s2;
		flt_s3   <= flt_s2;
	end

	// Stage 4: sums for B3 and for B4
	assign x1a = $signed(b2sq_s3[64:11]);
	assign x2a = $signed(ac2b6_s3[45:11]);
	assign x1b = $signed(ac3b6_s3[45:13]);
	assign x2b = $signed(b1sq_s3[64:16]);

	always_ff @(posedge clk) begin
		suma_s4 <= $signed({cal.ac1, 2'b00}) + x1a + x2a;
		sumb_s4 <= x1b + x2b + 51'sd2;
		t_s4    <= t_s3;
		up_s4   <= up_s3;
		flt_s4  <= flt_s3;
	end

	// Stage 5: B3 with division by four towards zero, B4 operand
	assign w_c     = (60'(suma_s4) <<< cal.oss) + 60'sd2;
	assign b3_corr = {31'b0, w_c[59] & (w_c[1:0] != 2'b00)};
	assign x3_lo   = sumb_s4[33:2];

	always_ff @(posedge clk) begin
		b3_s5  <= w_c[33:2] + b3_corr;
		op4_s5 <= x3_lo + X3_BIAS;
		t_s5   <= t_s4;
		up_s5  <= up_s4;
		flt_s5 <= flt_s4;
	end

	// Stage 6: B7 and the B4 product, both modulo 2^32
	assign diff_u = {13'b0, up_s5} - b3_s5;
	assign b7_k   = B7_SCALE >> cal.oss;
	assign b7_w   = diff_u * b7_k;
	assign b4_w   = cal.ac4 * op4_s5;

	always_ff @(posedge clk) begin
		b7_s6  <= b7_w[31:0];
		b4p_s6 <= b4_w[31:0];
		t_s6   <= t_s5;
		flt_s6 <= flt_s5;
	end

	// Choose the dividend by the size of B7; flag a zero B4
	assign b4      = b4p_s6[31:15];
	assign big_b7  = b7_s6[31];
	assign dvd     = big_b7 ? {1'b0, b7_s6} : {b7_s6, 1'b0};
	assign flt_c   = flt_s6 | (b4 == 17'd0);
	assign side_in = {t_s6, flt_c, big_b7};

	bpc_udiv #(
		.DIVIDEND_W(33),
		.DIVISOR_W (17),
		.SIDE_W    (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s6),
		.dividend (dvd),
		.divisor  (b4),
		.side_in  (side_in),
		.out_valid(dv_vld),
		.quotient (dv_q),
		.side_out (dv_side)
	);

	assign {t_d, flt_d, big_d} = dv_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s8  <= dv_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			done    <= vld_s10;
		end
	end

	// Stage 8: raw pressure, doubled quotient for large B7
	always_ff @(posedge clk) begin
		p0_s8  <= big_d ? {dv_q, 1'b0} : {1'b0, dv_q};
		t_s8   <= t_d;
		flt_s8 <= flt_d;
	end

	// Stage 9: (p >> 8)^2 and the linear term
	always_ff @(posedge clk) begin
		sqp_s9 <= p0_s8[33:8] * p0_s8[33:8];
		m2_s9  <= $signed({1'b0, p0_s8}) * P_LIN_COEF;
		p0_s9  <= p0_s8;
		t_s9   <= t_s8;
		flt_s9 <= flt_s8;
	end

	// Stage 10: scale both terms
	assign sqc_w = sqp_s9 * P_SQ_COEF;

	always_ff @(posedge clk) begin
		x1c_s10 <= sqc_w[63:16];
		x2c_s10 <= $signed(m2_s9[48:16]);
		p0_s10  <= p0_s9;
		t_s10   <= t_s9;
		flt_s10 <= flt_s9;
	end

	// Stage 11: apply correction, saturate, zero on fault
	assign corr_sum = $signed({2'b00, x1c_s10}) + x2c_s10 + P_OFFSET;
	assign pf       = $signed({17'b0, p0_s10}) + $signed(corr_sum[49:4]);
	assign p_sat    = pf[50] ? 18'd0 : (pf > P_MAX) ? 18'h3FFFF : pf[17:0];

	always_ff @(posedge clk) begin
		temperature_tenths <= flt_s10 ? 16'sd0 : $signed(t_s10);
		pressure_pa        <= flt_s10 ? 18'd0 : p_sat;
		divide_fault       <= flt_s10;
	end

endmodule
